### hw/rtl/pbhq_pkg.sv
`default_nettype none

package pbhq_pkg;

  localparam int unsigned MaxBoxes = 64;
  localparam int unsigned SlotW    = 6;
  localparam int unsigned CountW   = 7;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned MoverW   = 16;
  localparam int unsigned TagW     = 8;
  localparam int unsigned KindW    = 2;

  typedef enum logic [1:0] {
    ActQuery = 2'd0,
    ActMin   = 2'd1,
    ActMax   = 2'd2,
    ActTags  = 2'd3
  } action_e;

  typedef enum logic [KindW-1:0] {
    HitNone   = 2'd0,
    HitStatic = 2'd1,
    HitRobot  = 2'd2
  } hit_kind_e;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StDone = 3'b100
  } back_state_e;

  typedef struct packed {
    logic [1:0]              action;
    logic [SlotW-1:0]        slot;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
    logic [MoverW-1:0]       mover_id;
    logic                    has_robot;
    logic [TagW-1:0]         robot_tag;
    logic                    has_nuke;
  } req_t;

  typedef struct packed {
    logic [KindW-1:0] hit_kind;
    logic [TagW-1:0]  hit_robot;
    logic             nuke_hit;
  } rsp_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } corner_t;

  typedef struct packed {
    logic [MoverW-1:0] owner;
    logic              has_robot;
    logic [TagW-1:0]   robot_tag;
    logic              has_nuke;
  } box_tags_t;

  typedef struct packed {
    action_e           op;
    logic [SlotW-1:0]  slot;
    corner_t           point;
    logic [MoverW-1:0] mover_id;
    box_tags_t         tags;
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/pbhq_front.sv
`default_nettype none

module pbhq_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire pbhq_pkg::req_t   req_i,
  output logic                  cmd_valid_o,
  output pbhq_pkg::cmd_t        cmd_o,
  input  wire logic             cmd_pop_i
);

  pbhq_pkg::cmd_t buf_q [2];
  pbhq_pkg::cmd_t cmd_in;
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push, do_pop;

  always_comb begin
    cmd_in.op              = pbhq_pkg::action_e'(req_i.action);
    cmd_in.slot            = req_i.slot;
    cmd_in.point.x         = req_i.px;
    cmd_in.point.y         = req_i.py;
    cmd_in.point.z         = req_i.pz;
    cmd_in.mover_id        = req_i.mover_id;
    cmd_in.tags.owner      = req_i.mover_id;
    cmd_in.tags.has_robot  = req_i.has_robot;
    cmd_in.tags.robot_tag  = req_i.robot_tag;
    cmd_in.tags.has_nuke   = req_i.has_nuke;
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rd_ptr_q];
  assign do_push     = push & ~full;
  assign do_pop      = cmd_pop_i & cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pbhq_back.sv
`default_nettype none

module pbhq_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [pbhq_pkg::CountW-1:0] cfg_wdata_i,
  input  wire logic                        cmd_valid_i,
  input  wire pbhq_pkg::cmd_t              cmd_i,
  output logic                             cmd_pop_o,
  output logic                             empty,
  input  wire logic                        pop,
  output pbhq_pkg::rsp_t                   rsp_o
);

  pbhq_pkg::corner_t   min_mem [pbhq_pkg::MaxBoxes];
  pbhq_pkg::corner_t   max_mem [pbhq_pkg::MaxBoxes];
  pbhq_pkg::box_tags_t tag_mem [pbhq_pkg::MaxBoxes];
  pbhq_pkg::corner_t   min_rd_q, max_rd_q;
  pbhq_pkg::box_tags_t tag_rd_q;

  logic [pbhq_pkg::CountW-1:0] cfg_q, limit;
  pbhq_pkg::back_state_e       state_q, state_d;
  logic [pbhq_pkg::CountW-1:0] iss_q, iss_d;
  logic                        last_q, last_d;
  logic [pbhq_pkg::SlotW-1:0]  rd_addr;
  pbhq_pkg::corner_t           pt_q, pt_d;
  logic [pbhq_pkg::MoverW-1:0] mover_q, mover_d;
  pbhq_pkg::hit_kind_e         kind_q, kind_d;
  logic [pbhq_pkg::TagW-1:0]   tag_q, tag_d;
  logic                        nuke_q, nuke_d;
  logic                        wr_min, wr_max, wr_tags, hit;

  pbhq_pkg::rsp_t rq_q [2];
  pbhq_pkg::rsp_t rsp_new;
  logic           rq_wr_q, rq_rd_q;
  logic [1:0]     rq_cnt_q, rq_cnt_d;
  logic           rq_push, rq_pop, rq_full;

  assign limit = (cfg_q > pbhq_pkg::CountW'(pbhq_pkg::MaxBoxes)) ?
                 pbhq_pkg::CountW'(pbhq_pkg::MaxBoxes) : cfg_q;

  assign hit = ($signed(pt_q.x) >= $signed(min_rd_q.x)) &&
               ($signed(pt_q.x) <= $signed(max_rd_q.x)) &&
               ($signed(pt_q.y) >= $signed(min_rd_q.y)) &&
               ($signed(pt_q.y) <= $signed(max_rd_q.y)) &&
               ($signed(pt_q.z) >= $signed(min_rd_q.z)) &&
               ($signed(pt_q.z) <= $signed(max_rd_q.z)) &&
               (mover_q != tag_rd_q.owner);

  assign rq_full = (rq_cnt_q == 2'd2);
  assign empty   = (rq_cnt_q == 2'd0);
  assign rsp_o   = rq_q[rq_rd_q];
  assign rq_pop  = pop & ~empty;

  always_comb begin
    rsp_new.hit_kind  = kind_q;
    rsp_new.hit_robot = tag_q;
    rsp_new.nuke_hit  = nuke_q;
  end

  always_comb begin
    state_d   = state_q;
    iss_d     = iss_q;
    last_d    = last_q;
    pt_d      = pt_q;
    mover_d   = mover_q;
    kind_d    = kind_q;
    tag_d     = tag_q;
    nuke_d    = nuke_q;
    rd_addr   = iss_q[pbhq_pkg::SlotW-1:0];
    cmd_pop_o = 1'b0;
    wr_min    = 1'b0;
    wr_max    = 1'b0;
    wr_tags   = 1'b0;
    rq_push   = 1'b0;
    unique case (state_q)
      pbhq_pkg::StIdle: begin
        rd_addr = '0;
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            pbhq_pkg::ActQuery: begin
              pt_d    = cmd_i.point;
              mover_d = cmd_i.mover_id;
              kind_d  = pbhq_pkg::HitNone;
              tag_d   = '0;
              nuke_d  = 1'b0;
              iss_d   = pbhq_pkg::CountW'(1);
              last_d  = (limit == pbhq_pkg::CountW'(1));
              state_d = (limit == '0) ? pbhq_pkg::StDone : pbhq_pkg::StScan;
            end
            pbhq_pkg::ActMin:  wr_min  = 1'b1;
            pbhq_pkg::ActMax:  wr_max  = 1'b1;
            pbhq_pkg::ActTags: wr_tags = 1'b1;
            default: ;
          endcase
        end
      end
      pbhq_pkg::StScan: begin
        if (hit) begin
          if (kind_q == pbhq_pkg::HitNone) begin
            if (tag_rd_q.has_robot) begin
              kind_d = pbhq_pkg::HitRobot;
              tag_d  = tag_rd_q.robot_tag;
            end else begin
              kind_d = pbhq_pkg::HitStatic;
            end
          end
          if (tag_rd_q.has_nuke) begin
            nuke_d = 1'b1;
          end
        end
        if (last_q) begin
          state_d = pbhq_pkg::StDone;
        end else begin
          iss_d  = iss_q + pbhq_pkg::CountW'(1);
          last_d = ((iss_q + pbhq_pkg::CountW'(1)) == limit);
        end
      end
      pbhq_pkg::StDone: begin
        if (!rq_full) begin
          rq_push = 1'b1;
          state_d = pbhq_pkg::StIdle;
        end
      end
      default: state_d = pbhq_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_min) begin
      min_mem[cmd_i.slot] <= cmd_i.point;
    end
    min_rd_q <= min_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_max) begin
      max_mem[cmd_i.slot] <= cmd_i.point;
    end
    max_rd_q <= max_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_tags) begin
      tag_mem[cmd_i.slot] <= cmd_i.tags;
    end
    tag_rd_q <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    pt_q    <= pt_d;
    mover_q <= mover_d;
    tag_q   <= tag_d;
    nuke_q  <= nuke_d;
    if (rq_push) begin
      rq_q[rq_wr_q] <= rsp_new;
    end
  end

  always_comb begin
    rq_cnt_d = rq_cnt_q;
    if (rq_push && !rq_pop) begin
      rq_cnt_d = rq_cnt_q + 2'd1;
    end else if (!rq_push && rq_pop) begin
      rq_cnt_d = rq_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= '0;
      state_q  <= pbhq_pkg::StIdle;
      iss_q    <= '0;
      last_q   <= 1'b0;
      kind_q   <= pbhq_pkg::HitNone;
      rq_wr_q  <= 1'b0;
      rq_rd_q  <= 1'b0;
      rq_cnt_q <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      state_q  <= state_d;
      iss_q    <= iss_d;
      last_q   <= last_d;
      kind_q   <= kind_d;
      rq_wr_q  <= rq_wr_q ^ rq_push;
      rq_rd_q  <= rq_rd_q ^ rq_pop;
      rq_cnt_q <= rq_cnt_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/point_box_hit_query_top.sv
// Channel   Direction  Handshake          Payload
// request   in         push / full        req_i  (pbhq_pkg::req_t)
// result    out        empty / pop        rsp_o  (pbhq_pkg::rsp_t)
// config    in         cfg_we_i           cfg_wdata_i (boxes in use, 7 bits)
//
// A write request is written into the box table when the back end takes it while idle.
// A query scans min(boxes_in_use, 64) slots: the box table has one read port
// and is scanned one slot per cycle; the result is then posted when the output queue has room.
// Reset clears all control state; the box table is not cleared.
// Two-entry queues at the input and the output let each side stall independently.
`default_nettype none

module point_box_hit_query_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire pbhq_pkg::req_t              req_i,
  output logic                             empty,
  input  wire logic                        pop,
  output pbhq_pkg::rsp_t                   rsp_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [pbhq_pkg::CountW-1:0] cfg_wdata_i
);

  logic           cmd_valid;
  logic           cmd_pop;
  pbhq_pkg::cmd_t cmd;

  pbhq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  pbhq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

### hw/rtl/pbhq_checker.sv
`default_nettype none

module pbhq_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           full,
  input wire logic           empty,
  input wire pbhq_pkg::rsp_t rsp_o
);

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> (!full && empty))
    else $error("queues not empty during reset");

  a_nuke_is_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.nuke_hit) |-> (rsp_o.hit_kind != pbhq_pkg::HitNone))
    else $error("nuke reported without any hit");

  a_tag_only_robot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (rsp_o.hit_kind != pbhq_pkg::HitRobot)) |-> (rsp_o.hit_robot == '0))
    else $error("robot tag reported for a non-robot result");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (rsp_o.hit_kind == pbhq_pkg::HitNone ||
                rsp_o.hit_kind == pbhq_pkg::HitStatic ||
                rsp_o.hit_kind == pbhq_pkg::HitRobot))
    else $error("illegal hit kind");

  a_empty_after_reset: assert property (@(posedge clk_i)
    (rst_ni && $past(!rst_ni)) |-> empty)
    else $error("result present right after reset");

endmodule

bind point_box_hit_query_top pbhq_checker u_pbhq_checker (.*);

`default_nettype wire
